/* rtl/rdft_pkg.sv */
// shared types and constants for the receive descriptor frame tracker
package rdft_pkg;

  // ring depth default and descriptor status word layout
  localparam int RING_DEPTH_DEF = 4;
  localparam int OWN_BIT        = 31;
  localparam int LEN_LSB        = 16;
  localparam int LEN_MSB        = 29;
  localparam int FIRST_BIT      = 9;
  localparam int LAST_BIT       = 8;
  localparam int CRC_BYTES      = 4;

  // external field widths
  localparam int STATUS_W  = 32;
  localparam int LEN_W     = 14;
  localparam int IDX_OUT_W = 6;
  localparam int SEG_OUT_W = 7;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  // input op codes
  localparam logic OP_POLL    = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // result kinds
  localparam logic KIND_POLL    = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic poll;       // poll beat accepted
    logic rel_start;  // release beat accepted with a frame pending
    logic rel_emit;   // write one released entry into the output register
  } rdft_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_pending;
    logic rel_final;  // next released entry closes the run
    logic out_free;   // output register can take a beat this cycle
  } rdft_status_t;

endpackage

/* rtl/rdft_ctrl.sv */
// controller state machine: sequences poll answers and release runs
module rdft_ctrl import rdft_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_op,
  output logic         in_ready,
  input  rdft_status_t st,
  output rdft_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_REL  = 1'b1;

  logic state_r, state_nxt;
  logic accept;

  assign in_ready = (state_r == ST_IDLE) && st.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.poll      = accept && (in_op == OP_POLL);
    cmd.rel_start = accept && (in_op == OP_RELEASE) && st.frame_pending;
    cmd.rel_emit  = (state_r == ST_REL) && st.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.rel_start) state_nxt = ST_REL;
      end
      ST_REL: begin
        if (cmd.rel_emit && st.rel_final) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/rdft_dpath.sv */
// datapath: ring tracking registers, release walker and output register
module rdft_dpath import rdft_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rdft_cmd_t           cmd,
  output rdft_status_t        st,
  input  logic [STATUS_W-1:0] desc_status,
  input  logic                rx_buffer_unavailable,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                out_kind,
  output logic                out_last,
  output logic                out_frame_ready,
  output logic [LEN_W-1:0]    out_frame_length,
  output logic [IDX_OUT_W-1:0] out_buffer_index,
  output logic [IDX_OUT_W-1:0] out_frame_desc_index,
  output logic [SEG_OUT_W-1:0] out_segment_total,
  output logic [IDX_OUT_W-1:0] out_released_index,
  output logic                out_resume_reception
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(RING_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [LEN_W-1:0] CRC_LEN = LEN_W'(CRC_BYTES);

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_TOP) ? '0 : i + IDX_W'(1);
  endfunction

  // tracking state
  logic [IDX_W-1:0] ring_pos_r, ring_pos_nxt;
  logic [IDX_W-1:0] first_idx_r, first_idx_nxt;
  logic [IDX_W-1:0] last_idx_r, last_idx_nxt;
  logic [CNT_W-1:0] seg_cnt_r, seg_cnt_nxt;
  logic             pending_r, pending_nxt;

  // release walker
  logic [IDX_W-1:0] walk_idx_r, walk_idx_nxt;
  logic [CNT_W-1:0] walk_left_r, walk_left_nxt;
  logic             unavail_r, unavail_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic                 kind_r, last_r, ready_r, resume_r;
  logic [LEN_W-1:0]     len_r;
  logic [IDX_W-1:0]     buf_r, fdesc_r, rel_r;
  logic [CNT_W-1:0]     tot_r;

  // poll decode
  logic             own, is_last, is_first, skip;
  logic [LEN_W-1:0] len_field;
  logic [CNT_W-1:0] cnt_up;
  logic             rel_fin;

  assign own       = desc_status[OWN_BIT];
  assign is_last   = desc_status[LAST_BIT];
  assign is_first  = desc_status[FIRST_BIT];
  assign len_field = desc_status[LEN_MSB:LEN_LSB];
  assign skip      = pending_r || own;
  assign cnt_up    = (seg_cnt_r < CNT_MAX) ? seg_cnt_r + CNT_ONE : CNT_MAX;
  assign rel_fin   = (walk_left_r == CNT_ONE);

  always_comb begin
    st.frame_pending = pending_r;
    st.rel_final     = rel_fin;
    st.out_free      = !out_valid_r || out_ready;
  end

  always_comb begin
    ring_pos_nxt  = ring_pos_r;
    first_idx_nxt = first_idx_r;
    last_idx_nxt  = last_idx_r;
    seg_cnt_nxt   = seg_cnt_r;
    pending_nxt   = pending_r;
    walk_idx_nxt  = walk_idx_r;
    walk_left_nxt = walk_left_r;
    unavail_nxt   = unavail_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.poll) begin
      out_valid_nxt = 1'b1;
      if (!skip) begin
        ring_pos_nxt = idx_inc(ring_pos_r);
        priority if (is_last) begin
          seg_cnt_nxt  = cnt_up;
          last_idx_nxt = ring_pos_r;
          pending_nxt  = 1'b1;
        end else if (is_first) begin
          first_idx_nxt = ring_pos_r;
          seg_cnt_nxt   = CNT_ONE;
        end else begin
          seg_cnt_nxt = cnt_up;
        end
      end
    end

    if (cmd.rel_start) begin
      walk_idx_nxt  = (seg_cnt_r > CNT_ONE) ? first_idx_r : last_idx_r;
      walk_left_nxt = seg_cnt_r;
      unavail_nxt   = rx_buffer_unavailable;
    end

    if (cmd.rel_emit) begin
      out_valid_nxt = 1'b1;
      walk_idx_nxt  = idx_inc(walk_idx_r);
      walk_left_nxt = walk_left_r - CNT_ONE;
      if (rel_fin) begin
        seg_cnt_nxt = '0;
        pending_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_pos_r  <= '0;
      first_idx_r <= '0;
      last_idx_r  <= '0;
      seg_cnt_r   <= '0;
      pending_r   <= 1'b0;
      walk_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ring_pos_r  <= ring_pos_nxt;
      first_idx_r <= first_idx_nxt;
      last_idx_r  <= last_idx_nxt;
      seg_cnt_r   <= seg_cnt_nxt;
      pending_r   <= pending_nxt;
      walk_left_r <= walk_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_idx_r <= walk_idx_nxt;
    unavail_r  <= unavail_nxt;
  end

  // result payload, loaded only when a beat enters the output register
  always_ff @(posedge clk) begin
    if (cmd.poll) begin
      kind_r   <= KIND_POLL;
      last_r   <= 1'b0;
      resume_r <= 1'b0;
      rel_r    <= '0;
      ready_r  <= !skip && is_last;
      if (!skip && is_last) begin
        len_r   <= (len_field >= CRC_LEN) ? len_field - CRC_LEN : '0;
        buf_r   <= (cnt_up > CNT_ONE) ? first_idx_r : ring_pos_r;
        fdesc_r <= ring_pos_r;
        tot_r   <= cnt_up;
      end else begin
        len_r   <= '0;
        buf_r   <= '0;
        fdesc_r <= '0;
        tot_r   <= '0;
      end
    end else if (cmd.rel_emit) begin
      kind_r   <= KIND_RELEASE;
      last_r   <= rel_fin;
      resume_r <= rel_fin && unavail_r;
      rel_r    <= walk_idx_r;
      ready_r  <= 1'b0;
      len_r    <= '0;
      buf_r    <= '0;
      fdesc_r  <= '0;
      tot_r    <= '0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_kind             = kind_r;
  assign out_last             = last_r;
  assign out_frame_ready      = ready_r;
  assign out_frame_length     = len_r;
  assign out_buffer_index     = IDX_OUT_W'(buf_r);
  assign out_frame_desc_index = IDX_OUT_W'(fdesc_r);
  assign out_segment_total    = SEG_OUT_W'(tot_r);
  assign out_released_index   = IDX_OUT_W'(rel_r);
  assign out_resume_reception = resume_r;

endmodule

/* rtl/rx_descriptor_frame_tracker_core.sv */
// top level of the receive descriptor ring frame tracker
// usage:
// - input stream: in_tuser selects a poll of the descriptor at the current
//   ring position or a release of the pending frame; in_tdata carries the
//   descriptor status word and the buffer-unavailable flag
// - result stream: out_tuser gives the beat kind, out_tlast closes a
//   release run; every poll gives exactly one beat, a release gives one beat
//   per descriptor of the frame, a release with no frame pending gives none
// - order: a poll answer sits in the output register in the cycle after the
//   input beat is taken; a release run starts once the controller is in its
//   release state and the output register is free; polls go back to back
// - throughput: a release holds in_tready low while the walker emits one entry
//   per cycle the receiver takes, so the release walk sets the rate
// - the next input beat is taken while a poll answer still waits in the
//   output register, as long as the receiver takes it in the same cycle
// - receiver stall: the output register holds its beat and the walker
//   and input side wait; nothing is dropped
// - reset (rst_n low, synchronous) puts the ring at descriptor zero with
//   no frame pending and empties the output register
module rx_descriptor_frame_tracker_core import rdft_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] desc_status, [32] rx_buffer_unavailable
  input  logic [0:0]            in_tuser,   // [0] op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [0] frame_ready, [14:1] frame_length,
                                            // [20:15] buffer_index, [26:21] frame_desc_index,
                                            // [33:27] segment_total, [39:34] released_index,
                                            // [40] resume_reception
  output logic [0:0]            out_tuser,  // [0] kind
  output logic                  out_tlast
);

  rdft_cmd_t    cmd;
  rdft_status_t st;

  logic                 frame_ready;
  logic [LEN_W-1:0]     frame_length;
  logic [IDX_OUT_W-1:0] buffer_index;
  logic [IDX_OUT_W-1:0] frame_desc_index;
  logic [SEG_OUT_W-1:0] segment_total;
  logic [IDX_OUT_W-1:0] released_index;
  logic                 resume_reception;
  logic                 kind;

  rdft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser[0]),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  rdft_dpath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .st                    (st),
    .desc_status           (in_tdata[STATUS_W-1:0]),
    .rx_buffer_unavailable (in_tdata[STATUS_W]),
    .out_ready             (out_tready),
    .out_valid             (out_tvalid),
    .out_kind              (kind),
    .out_last              (out_tlast),
    .out_frame_ready       (frame_ready),
    .out_frame_length      (frame_length),
    .out_buffer_index      (buffer_index),
    .out_frame_desc_index  (frame_desc_index),
    .out_segment_total     (segment_total),
    .out_released_index    (released_index),
    .out_resume_reception  (resume_reception)
  );

  // pack result fields from the lowest bit up, pad to whole bytes
  assign out_tuser = kind;
  assign out_tdata = {7'b0, resume_reception, released_index, segment_total,
                      frame_desc_index, buffer_index, frame_length, frame_ready};

  // while a non-final release entry is held the run is open, so no input is taken
  a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (kind == KIND_RELEASE) && !out_tlast |-> !in_tready)
    else $error("input taken in the middle of a release run");

  // poll answers never carry release fields
  a_poll_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (kind == KIND_POLL) |->
      !out_tlast && !resume_reception && (released_index == '0))
    else $error("poll answer carries release fields");

  // resume request only on the closing entry of a run
  a_resume_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && resume_reception |-> out_tlast && (kind == KIND_RELEASE))
    else $error("resume outside the closing release entry");

  // a reported frame always spans at least one descriptor
  a_frame_has_segments: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && frame_ready |-> (segment_total != '0) && (kind == KIND_POLL))
    else $error("frame reported with zero segments");

endmodule
